@@ hdl/tpr_pkg.sv @@
`default_nettype none

package tpr_pkg;

	localparam int unsigned FRACTION_BITS_DEF = 14;
	localparam int unsigned RAW_W = 12;
	localparam int unsigned CFG_INDEX_W = 2;

	// Item opcodes.
	localparam logic [1:0] OP_BYTE    = 2'd0;
	localparam logic [1:0] OP_POLL    = 2'd1;
	localparam logic [1:0] OP_TIMEOUT = 2'd2;

	// Result kinds.
	localparam logic [1:0] EV_POLL     = 2'd0;
	localparam logic [1:0] EV_POSITION = 2'd1;
	localparam logic [1:0] EV_ERROR    = 2'd2;

	// Configuration register indexes.
	localparam logic [CFG_INDEX_W-1:0] REG_X_MIN = 2'd0;
	localparam logic [CFG_INDEX_W-1:0] REG_X_MAX = 2'd1;
	localparam logic [CFG_INDEX_W-1:0] REG_Y_MIN = 2'd2;
	localparam logic [CFG_INDEX_W-1:0] REG_Y_MAX = 2'd3;

	localparam logic [RAW_W-1:0] X_MIN_RST = 12'd440;
	localparam logic [RAW_W-1:0] X_MAX_RST = 12'd3537;
	localparam logic [RAW_W-1:0] Y_MIN_RST = 12'd632;
	localparam logic [RAW_W-1:0] Y_MAX_RST = 12'd3270;

	localparam logic [7:0] HDR_POSITION = 8'hEE;
	localparam logic [7:0] HDR_ACK0     = 8'hC8;
	localparam logic [7:0] HDR_ACK1     = 8'hCA;
	localparam logic [7:0] BUTTON_DOWN  = 8'h51;
	localparam logic [7:0] COORD_MASK   = 8'h3F;

	typedef struct packed {
		logic [1:0] opcode;
		logic [7:0] rx_byte;
	} in_word_t;

	typedef struct packed {
		logic [1:0]        event_kind;
		logic              button_down;
		logic [11:0]       raw_x;
		logic [11:0]       raw_y;
		logic signed [15:0] norm_x;
		logic signed [15:0] norm_y;
	} out_word_t;

	typedef struct packed {
		logic accept;
		logic div_start;
		logic div_sel_y;
		logic store_x;
		logic store_y;
	} ctrl_cmd_t;

	typedef struct packed {
		logic pos_packet;
		logic div_done;
		logic out_busy;
	} ctrl_sts_t;

endpackage

`default_nettype wire

@@ hdl/touch_panel_packet_receiver.sv @@
`default_nettype none

// Touch-panel packet receiver. Each input word is a received byte, a poll slot or a receive
// timeout; a poll slot gives a send-poll word when no reply is pending, a timeout or a bad
// checksum gives an error word, and a good position packet gives one position word with raw
// and calibrated coordinates. The checksum byte of a position packet runs two divisions,
// X and then Y, one after the other through a single restoring divider, one quotient bit
// a cycle; the next word is not taken until both are done. A word is also held off while
// a finished result waits on the output. Calibration registers are written through the
// configuration port, which is always ready, and should be written only while the block is
// idle.
module touch_panel_packet_receiver #(
	parameter int unsigned FRACTION_BITS = tpr_pkg::FRACTION_BITS_DEF
) (
	input  wire logic                            clk,
	input  wire logic                            arst_n,
	input  wire logic                            in_valid,
	output logic                                 in_ready,
	input  wire tpr_pkg::in_word_t               in_data,
	output logic                                 out_valid,
	input  wire logic                            out_ready,
	output tpr_pkg::out_word_t                   out_data,
	input  wire logic                            cfg_valid,
	output logic                                 cfg_ready,
	input  wire logic [tpr_pkg::CFG_INDEX_W-1:0] cfg_index,
	input  wire logic [tpr_pkg::RAW_W-1:0]       cfg_data
);
	import tpr_pkg::*;

	ctrl_cmd_t cmd;
	ctrl_sts_t sts;

	assign cfg_ready = 1'b1;

	tpr_ctrl u_ctrl (
		.clk     (clk),
		.arst_n  (arst_n),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.cmd     (cmd),
		.sts     (sts)
	);

	tpr_datapath #(
		.FRACTION_BITS(FRACTION_BITS)
	) u_datapath (
		.clk      (clk),
		.arst_n   (arst_n),
		.cmd      (cmd),
		.sts      (sts),
		.in_data  (in_data),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.out_data (out_data),
		.cfg_we   (cfg_valid && cfg_ready),
		.cfg_index(cfg_index),
		.cfg_data (cfg_data)
	);

endmodule

`default_nettype wire

@@ hdl/tpr_div.sv @@
`default_nettype none

module tpr_div #(
	parameter int unsigned FRACTION_BITS = tpr_pkg::FRACTION_BITS_DEF
) (
	input  wire logic                       clk,
	input  wire logic                       arst_n,
	input  wire logic                       start,
	input  wire logic [tpr_pkg::RAW_W-1:0]  raw,
	input  wire logic [tpr_pkg::RAW_W-1:0]  lo,
	input  wire logic [tpr_pkg::RAW_W-1:0]  hi,
	output logic                            done,
	output logic signed [15:0]              quot
);
	import tpr_pkg::*;

	localparam int unsigned NW = RAW_W + FRACTION_BITS;
	localparam int unsigned CW = $clog2(NW);

	logic signed [RAW_W:0] diff, span;
	logic [RAW_W:0]        diff_neg;
	logic [RAW_W-1:0]      mag;
	logic [RAW_W:0]        rem_sh;
	logic                  ge;
	logic [15:0]           q16, q16_neg;

	logic              busy_q, done_q, neg_q, zero_q;
	logic [CW-1:0]     cnt_q;
	logic [RAW_W-1:0]  den_q;
	logic [RAW_W:0]    rem_q;
	logic [NW-1:0]     num_q;

	always_comb begin
		diff     = $signed({1'b0, raw}) - $signed({1'b0, lo});
		span     = $signed({1'b0, hi}) - $signed({1'b0, lo});
		diff_neg = -diff;
		mag      = diff[RAW_W] ? diff_neg[RAW_W-1:0] : diff[RAW_W-1:0];
		rem_sh   = {rem_q[RAW_W-1:0], num_q[NW-1]};
		ge       = rem_sh >= {1'b0, den_q};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= CW'(NW - 1);
			end else if (busy_q) begin
				if (cnt_q == '0) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end else begin
					cnt_q <= cnt_q - 1'b1;
				end
			end
		end
	end

	// Restoring division of |diff| << FRACTION_BITS by the span, one quotient bit a cycle.
	always_ff @(posedge clk) begin
		if (start) begin
			num_q  <= {mag, {FRACTION_BITS{1'b0}}};
			rem_q  <= '0;
			den_q  <= span[RAW_W-1:0];
			neg_q  <= diff[RAW_W];
			zero_q <= span[RAW_W] || (span == '0);
		end else if (busy_q) begin
			rem_q <= ge ? rem_sh - {1'b0, den_q} : rem_sh;
			num_q <= {num_q[NW-2:0], ge};
		end
	end

	always_comb begin
		q16     = num_q[15:0];
		q16_neg = -q16;
		if (zero_q)
			quot = '0;
		else if (!neg_q)
			quot = (num_q > NW'(32767)) ? 16'sh7FFF : $signed(q16);
		else
			quot = (num_q > NW'(32768)) ? 16'sh8000 : $signed(q16_neg);
	end

	assign done = done_q;

	a_start_busy: assert property (@(posedge clk) disable iff (!arst_n)
		start |=> busy_q)
		else $error("divider did not start");
	a_done_idle: assert property (@(posedge clk) disable iff (!arst_n)
		done_q |-> !busy_q)
		else $error("divider reports done while busy");
	a_done_once: assert property (@(posedge clk) disable iff (!arst_n)
		done_q |=> !done_q)
		else $error("divider done held longer than one cycle");

endmodule

`default_nettype wire

@@ hdl/tpr_datapath.sv @@
`default_nettype none

module tpr_datapath #(
	parameter int unsigned FRACTION_BITS = tpr_pkg::FRACTION_BITS_DEF
) (
	input  wire logic                            clk,
	input  wire logic                            arst_n,
	input  wire tpr_pkg::ctrl_cmd_t              cmd,
	output tpr_pkg::ctrl_sts_t                   sts,
	input  wire tpr_pkg::in_word_t               in_data,
	output logic                                 out_valid,
	input  wire logic                            out_ready,
	output tpr_pkg::out_word_t                   out_data,
	input  wire logic                            cfg_we,
	input  wire logic [tpr_pkg::CFG_INDEX_W-1:0] cfg_index,
	input  wire logic [tpr_pkg::RAW_W-1:0]       cfg_data
);
	import tpr_pkg::*;

	localparam logic [2:0] LAST_POS = 3'd7;

	logic [2:0]        pos_q;
	logic [7:0]        xor_q;
	logic [7:0]        pkt_q [7];
	logic              await_q;
	logic              out_valid_q;
	out_word_t         out_q;
	logic [RAW_W-1:0]  x_min_q, x_max_q, y_min_q, y_max_q;

	logic              last, chk_ok, is_pos, is_ack;
	logic [RAW_W-1:0]  raw_x, raw_y, div_raw, div_lo, div_hi;
	logic              div_done;
	logic signed [15:0] div_quot;
	out_word_t         poll_word, err_word;

	always_comb begin
		last   = pos_q == LAST_POS;
		chk_ok = xor_q == in_data.rx_byte;
		is_pos = (pkt_q[0] == HDR_POSITION) && (pkt_q[1] == HDR_POSITION);
		is_ack = (pkt_q[0] == HDR_ACK0) && (pkt_q[1] == HDR_ACK1);
		raw_x  = {pkt_q[5][5:0] & COORD_MASK[5:0], pkt_q[6][5:0] & COORD_MASK[5:0]};
		raw_y  = {pkt_q[3][5:0] & COORD_MASK[5:0], pkt_q[4][5:0] & COORD_MASK[5:0]};
		div_raw = cmd.div_sel_y ? raw_y   : raw_x;
		div_lo  = cmd.div_sel_y ? y_min_q : x_min_q;
		div_hi  = cmd.div_sel_y ? y_max_q : x_max_q;
		poll_word            = '0;
		poll_word.event_kind = EV_POLL;
		err_word             = '0;
		err_word.event_kind  = EV_ERROR;
		sts.pos_packet = (in_data.opcode == OP_BYTE) && last && chk_ok && is_pos;
		sts.div_done   = div_done;
		sts.out_busy   = out_valid_q && !out_ready;
	end

	tpr_div #(
		.FRACTION_BITS(FRACTION_BITS)
	) u_div (
		.clk   (clk),
		.arst_n(arst_n),
		.start (cmd.div_start),
		.raw   (div_raw),
		.lo    (div_lo),
		.hi    (div_hi),
		.done  (div_done),
		.quot  (div_quot)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q       <= '0;
			xor_q       <= '0;
			await_q     <= 1'b0;
			out_valid_q <= 1'b0;
			x_min_q     <= X_MIN_RST;
			x_max_q     <= X_MAX_RST;
			y_min_q     <= Y_MIN_RST;
			y_max_q     <= Y_MAX_RST;
		end else begin
			if (cfg_we) begin
				unique case (cfg_index)
					REG_X_MIN: x_min_q <= cfg_data;
					REG_X_MAX: x_max_q <= cfg_data;
					REG_Y_MIN: y_min_q <= cfg_data;
					REG_Y_MAX: y_max_q <= cfg_data;
				endcase
			end
			if (out_valid_q && out_ready)
				out_valid_q <= 1'b0;
			if (cmd.store_y)
				out_valid_q <= 1'b1;
			if (cmd.accept) begin
				unique case (in_data.opcode)
					OP_POLL: begin
						if (!await_q) begin
							await_q     <= 1'b1;
							out_valid_q <= 1'b1;
						end
					end
					OP_TIMEOUT: begin
						pos_q       <= '0;
						xor_q       <= '0;
						out_valid_q <= 1'b1;
					end
					OP_BYTE: begin
						if (!last) begin
							xor_q <= xor_q ^ in_data.rx_byte;
							pos_q <= pos_q + 1'b1;
						end else begin
							pos_q <= '0;
							xor_q <= '0;
							if (!chk_ok)
								out_valid_q <= 1'b1;
							else if (is_pos || is_ack)
								await_q <= 1'b0;
						end
					end
					default: ;
				endcase
			end
		end
	end

	// Packet bytes and the result word need no reset.
	always_ff @(posedge clk) begin
		if (cmd.accept && (in_data.opcode == OP_BYTE) && !last)
			pkt_q[pos_q] <= in_data.rx_byte;
		if (cmd.accept) begin
			unique case (in_data.opcode)
				OP_POLL: out_q <= poll_word;
				OP_TIMEOUT: out_q <= err_word;
				OP_BYTE: begin
					if (last && !chk_ok) begin
						out_q <= err_word;
					end else if (sts.pos_packet) begin
						out_q.event_kind  <= EV_POSITION;
						out_q.button_down <= pkt_q[2] == BUTTON_DOWN;
						out_q.raw_x       <= raw_x;
						out_q.raw_y       <= raw_y;
					end
				end
				default: ;
			endcase
		end
		if (cmd.store_x)
			out_q.norm_x <= div_quot;
		if (cmd.store_y)
			out_q.norm_y <= div_quot;
	end

	assign out_valid = out_valid_q;
	assign out_data  = out_q;

	a_pos_clears_await: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.accept && sts.pos_packet |=> !await_q)
		else $error("position packet left a reply awaited");
	a_timeout_reframes: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.accept && (in_data.opcode == OP_TIMEOUT) |=> (pos_q == '0) && (xor_q == '0))
		else $error("timeout did not restart framing");
	a_emit_position: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.store_y |=> out_valid_q && (out_q.event_kind == EV_POSITION))
		else $error("finished position word not presented");

endmodule

`default_nettype wire

@@ hdl/tpr_ctrl.sv @@
`default_nettype none

module tpr_ctrl (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               in_valid,
	output logic                    in_ready,
	output tpr_pkg::ctrl_cmd_t      cmd,
	input  wire tpr_pkg::ctrl_sts_t sts
);
	import tpr_pkg::*;

	typedef enum logic [2:0] {
		ST_IDLE = 3'b001,
		ST_DIVX = 3'b010,
		ST_DIVY = 3'b100
	} state_t;

	state_t state_q, state_d;

	always_comb begin
		in_ready       = (state_q == ST_IDLE) && !sts.out_busy;
		cmd.accept     = in_valid && in_ready;
		cmd.store_x    = (state_q == ST_DIVX) && sts.div_done;
		cmd.store_y    = (state_q == ST_DIVY) && sts.div_done;
		cmd.div_sel_y  = state_q == ST_DIVX;
		cmd.div_start  = (cmd.accept && sts.pos_packet) || cmd.store_x;
		state_d        = state_q;
		unique case (state_q)
			ST_IDLE: if (cmd.accept && sts.pos_packet) state_d = ST_DIVX;
			ST_DIVX: if (sts.div_done) state_d = ST_DIVY;
			ST_DIVY: if (sts.div_done) state_d = ST_IDLE;
			default: state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			state_q <= ST_IDLE;
		else
			state_q <= state_d;
	end

	a_done_while_dividing: assert property (@(posedge clk) disable iff (!arst_n)
		sts.div_done |-> state_q != ST_IDLE)
		else $error("divider finished with no division under way");
	a_pos_starts_x: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.accept && sts.pos_packet |=> state_q == ST_DIVX)
		else $error("position packet did not start the X division");
	a_y_returns_idle: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.store_y |=> state_q == ST_IDLE)
		else $error("controller did not return to idle after Y");

endmodule

`default_nettype wire
